FILE: rtl/albs_pkg.sv
`timescale 1ns / 1ps

package albs_pkg;

	// Fixed field widths of the block.
	localparam int SAMPLE_W  = 12;
	localparam int LEVEL_W   = 12;
	localparam int SUM_W     = 16;
	localparam int THR_W     = 16;
	localparam int HALF_W    = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Divider iteration counter: one quotient bit per cycle.
	localparam int DIV_CNT_W = $clog2(LEVEL_W);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(LEVEL_W - 1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL        = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_STEP       = 2'd2;

	// Configuration reset values.
	localparam logic [THR_W-1:0]   RST_CHANGE_THRESHOLD = 16'd500;
	localparam logic [LEVEL_W-1:0] RST_MIN_LEVEL        = 12'd15;
	localparam logic [LEVEL_W-1:0] RST_LEVEL_STEP       = 12'd20;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_COMPARE,
		ST_AVERAGE,
		ST_SETUP,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic update;
		logic compare_load;
		logic average_load;
		logic div_setup;
		logic div_step;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic report;
	} status_t;

endpackage

FILE: rtl/albs_datapath.sv
`timescale 1ns / 1ps

module albs_datapath #(
	parameter int WINDOW  = 10,
	parameter int DISPLAY = 128
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  albs_pkg::cmd_t                   cmd,
	output albs_pkg::status_t                status,
	input  logic [albs_pkg::SAMPLE_W-1:0]    sample,
	input  logic                             cfg_valid,
	input  logic [albs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [albs_pkg::CFG_DAT_W-1:0]   cfg_data,
	output logic [albs_pkg::HALF_W-1:0]      half_size,
	output logic [albs_pkg::LEVEL_W-1:0]     average_level
);

	localparam int SLOT_W = $clog2(WINDOW);
	localparam int FILL_W = $clog2(WINDOW + 1);
	// Exact floor(sum / WINDOW) as (sum * AVG_MULT) >> AVG_SHIFT for any 16-bit sum.
	localparam int AVG_SHIFT = albs_pkg::SUM_W + $clog2(WINDOW);
	localparam longint unsigned AVG_MULT_L =
		((64'd1 << AVG_SHIFT) + longint'(WINDOW) - 1) / longint'(WINDOW);
	localparam int MULT_W = albs_pkg::SUM_W + 1;
	localparam int PROD_W = albs_pkg::SUM_W + MULT_W;
	localparam logic [MULT_W-1:0] AVG_MULT = MULT_W'(AVG_MULT_L);
	localparam logic [albs_pkg::LEVEL_W-1:0] DISPLAY_MAX = albs_pkg::LEVEL_W'(DISPLAY);

	localparam int LW = albs_pkg::LEVEL_W;
	localparam int SW = albs_pkg::SUM_W;

	// Configuration registers.
	logic [albs_pkg::THR_W-1:0] thr_q;
	logic [LW-1:0]              min_q;
	logic [LW-1:0]              step_q;

	// Filter state.
	logic [albs_pkg::SAMPLE_W-1:0] ring_q [WINDOW];
	logic [SLOT_W-1:0]             slot_q;
	logic [FILL_W-1:0]             fill_q;
	logic [SW-1:0]                 sum_q;
	logic [SW-1:0]                 reported_q;
	logic [albs_pkg::SAMPLE_W-1:0] sample_q;

	// Arithmetic state.
	logic [PROD_W-1:0] product_s1;
	logic [LW-1:0]     avg_q;
	logic [LW:0]       rem_q;
	logic [LW-1:0]     quo_q;
	logic [LW-1:0]     div_q;

	logic [albs_pkg::HALF_W-1:0] half_q;
	logic [LW-1:0]               avg_out_q;

	logic                        full;
	logic [albs_pkg::SAMPLE_W-1:0] oldest;
	logic [SW-1:0]               sum_next;
	logic [SW-1:0]               diff;
	logic [LW-1:0]               dividend;
	logic [LW-1:0]               step_eff;
	logic [LW:0]                 shifted;
	logic                        fits;
	logic [LW-1:0]               clamped;

	always_comb begin
		full     = (fill_q == FILL_W'(WINDOW));
		oldest   = full ? ring_q[slot_q] : '0;
		sum_next = sum_q - SW'(oldest) + SW'(sample_q);
		diff     = (sum_q > reported_q) ? (sum_q - reported_q) : (reported_q - sum_q);
		status.report = (diff > thr_q);
		dividend = (avg_q > min_q) ? (avg_q - min_q) : '0;
		step_eff = (step_q == '0) ? LW'(1) : step_q;
		shifted  = {rem_q[LW-1:0], quo_q[LW-1]};
		fits     = (shifted >= {1'b0, div_q});
		clamped  = (quo_q > DISPLAY_MAX) ? DISPLAY_MAX : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= albs_pkg::RST_CHANGE_THRESHOLD;
			min_q  <= albs_pkg::RST_MIN_LEVEL;
			step_q <= albs_pkg::RST_LEVEL_STEP;
		end else if (cfg_valid) begin
			case (cfg_index)
				albs_pkg::CFG_CHANGE_THRESHOLD: thr_q  <= cfg_data;
				albs_pkg::CFG_MIN_LEVEL:        min_q  <= cfg_data[LW-1:0];
				albs_pkg::CFG_LEVEL_STEP:       step_q <= cfg_data[LW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q     <= '0;
			fill_q     <= '0;
			sum_q      <= '0;
			reported_q <= '0;
		end else begin
			if (cmd.update) begin
				sum_q  <= sum_next;
				slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
				if (!full) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
			if (cmd.compare_load) begin
				reported_q <= sum_q;
			end
		end
	end

	// Sample ring and arithmetic registers carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= sample;
		end
		if (cmd.update) begin
			ring_q[slot_q] <= sample_q;
		end
		if (cmd.compare_load) begin
			product_s1 <= PROD_W'(sum_q) * PROD_W'(AVG_MULT);
		end
		if (cmd.average_load) begin
			avg_q <= product_s1[AVG_SHIFT +: LW];
		end
		if (cmd.div_setup) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= step_eff;
		end else if (cmd.div_step) begin
			rem_q <= fits ? (shifted - {1'b0, div_q}) : shifted;
			quo_q <= {quo_q[LW-2:0], fits};
		end
		if (cmd.out_load) begin
			half_q    <= clamped[albs_pkg::HALF_W:1];
			avg_out_q <= avg_q;
		end
	end

	assign half_size     = half_q;
	assign average_level = avg_out_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW))
		else $error("fill count past window length");

	a_reported: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.compare_load |=> reported_q == $past(sum_q))
		else $error("reported sum not recorded");

endmodule

FILE: rtl/albs_ctrl.sv
`timescale 1ns / 1ps

module albs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  albs_pkg::status_t status,
	output albs_pkg::cmd_t    cmd
);

	albs_pkg::state_t                  state_q;
	albs_pkg::state_t                  state_next;
	logic [albs_pkg::DIV_CNT_W-1:0]    count_q;
	logic                              out_valid_q;
	logic                              out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_next = state_q;
		case (state_q)
			albs_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_next = albs_pkg::ST_UPDATE;
				end
			end
			albs_pkg::ST_UPDATE:  state_next = albs_pkg::ST_COMPARE;
			albs_pkg::ST_COMPARE: begin
				state_next = status.report ? albs_pkg::ST_AVERAGE : albs_pkg::ST_IDLE;
			end
			albs_pkg::ST_AVERAGE: state_next = albs_pkg::ST_SETUP;
			albs_pkg::ST_SETUP:   state_next = albs_pkg::ST_DIVIDE;
			albs_pkg::ST_DIVIDE: begin
				if (count_q == albs_pkg::DIV_LAST) begin
					state_next = albs_pkg::ST_DONE;
				end
			end
			albs_pkg::ST_DONE: begin
				if (out_free) begin
					state_next = albs_pkg::ST_IDLE;
				end
			end
			default: state_next = albs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			albs_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			albs_pkg::ST_UPDATE:  cmd.update       = 1'b1;
			albs_pkg::ST_COMPARE: cmd.compare_load = status.report;
			albs_pkg::ST_AVERAGE: cmd.average_load = 1'b1;
			albs_pkg::ST_SETUP:   cmd.div_setup    = 1'b1;
			albs_pkg::ST_DIVIDE:  cmd.div_step     = 1'b1;
			albs_pkg::ST_DONE:    cmd.out_load     = out_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= albs_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (state_q == albs_pkg::ST_DIVIDE) begin
				count_q <= count_q + albs_pkg::DIV_CNT_W'(1);
			end else begin
				count_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("pending result overwritten");

	a_accept_update: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == albs_pkg::ST_UPDATE)
		else $error("accepted request not processed");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == albs_pkg::ST_DIVIDE && count_q == albs_pkg::DIV_LAST)
		|=> state_q == albs_pkg::ST_DONE)
		else $error("divider did not finish on time");

endmodule

FILE: rtl/averaged_level_to_box_size_unit.sv
`timescale 1ns / 1ps

// Moving-average level filter with a change threshold. Each request carries one
// 12-bit sample; the block keeps the last WINDOW samples and their running sum,
// and after the sample is added it compares the sum with the last reported sum.
// When they differ by more than change_threshold it delivers one result: the
// average level (sum / WINDOW) and half of the box size, where the size is
// (average - min_level) / level_step, zero below min_level, saturated at DISPLAY.
// Otherwise the request produces no result. A request that reports nothing
// passes only the update and compare steps; one that produces a result also
// passes the averaging step and the restoring divider for level_step, which
// retires one quotient bit per cycle. Only one request is in flight at a
// time, but a finished result sits in an output register, so new requests
// are taken while it waits; a result-producing request holds its last cycle
// until that register is free. The configuration port is always ready and its
// writes should be issued only while the block is idle.
module averaged_level_to_box_size_unit #(
	parameter int WINDOW  = 10,
	parameter int DISPLAY = 128
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [albs_pkg::SAMPLE_W-1:0]  sample,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [albs_pkg::HALF_W-1:0]    half_size,
	output logic [albs_pkg::LEVEL_W-1:0]   average_level,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [albs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [albs_pkg::CFG_DAT_W-1:0] cfg_data
);

	albs_pkg::cmd_t    cmd;
	albs_pkg::status_t status;

	// Register writes are never held off.
	assign cfg_ready = 1'b1;

	albs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	albs_datapath #(
		.WINDOW  (WINDOW),
		.DISPLAY (DISPLAY)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.sample        (sample),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.half_size     (half_size),
		.average_level (average_level)
	);

endmodule
